// File: design/hvn_pkg.sv
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared types, constants and helpers for the heightmap vertex normal block.
// ----------------------------------------------------------------------------
package hvn_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_ROWS_DEF    = 4096;

    // Q1.14 unit and quotient width of the normalizer divide
    localparam int Q_ONE     = 16384;
    localparam int QW        = 15;
    localparam int DIV_STEPS = 15;

    // configuration register indexes
    localparam logic [7:0] CFG_COLUMN_SPACING = 8'd0;
    localparam logic [7:0] CFG_ROW_SPACING    = 8'd1;
    localparam logic [7:0] CFG_GRID_COLUMNS   = 8'd2;
    localparam logic [7:0] CFG_GRID_ROWS      = 8'd3;

    // edge side mask bits
    localparam logic [3:0] SIDE_L = 4'b0001;
    localparam logic [3:0] SIDE_R = 4'b0010;
    localparam logic [3:0] SIDE_U = 4'b0100;
    localparam logic [3:0] SIDE_D = 4'b1000;

    // window slot of the center vertex
    localparam logic [3:0] WIN_CENTER = 4'd4;

    typedef struct packed {
        logic [9:0]         col_index;
        logic [11:0]        row_index;
        logic signed [15:0] elev_center;
        logic signed [15:0] elev_up;
        logic signed [15:0] elev_down;
        logic signed [15:0] elev_left;
        logic signed [15:0] elev_right;
        logic signed [15:0] elev_up_left;
        logic signed [15:0] elev_up_right;
        logic signed [15:0] elev_down_left;
        logic signed [15:0] elev_down_right;
    } t_in;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } t_out;

    // one triangle around the vertex: normal = v(ac,ar) x v(bc,br)
    typedef struct packed {
        logic               present;
        logic [3:0]         sides;
        logic signed [1:0]  ac;
        logic signed [1:0]  ar;
        logic signed [1:0]  bc;
        logic signed [1:0]  br;
    } t_tri;

    function automatic t_tri mk_tri(logic [3:0] s, int ac, int ar, int bc, int br);
        t_tri t;
        t.present = 1'b1;
        t.sides   = s;
        t.ac      = 2'(ac);
        t.ar      = 2'(ar);
        t.bc      = 2'(bc);
        t.br      = 2'(br);
        return t;
    endfunction

    function automatic t_tri tri_info(logic odd, logic [2:0] slot);
        t_tri t;
        t = '0;
        if (!odd) begin
            case (slot)
                3'd0:    t = mk_tri(SIDE_L | SIDE_U, -1, -1,  0, -1);
                3'd1:    t = mk_tri(SIDE_L | SIDE_U, -1,  0, -1, -1);
                3'd2:    t = mk_tri(SIDE_L | SIDE_D, -1,  1, -1,  0);
                3'd3:    t = mk_tri(SIDE_L | SIDE_D,  0,  1, -1,  1);
                3'd4:    t = mk_tri(SIDE_R | SIDE_U,  1, -1,  1,  0);
                3'd5:    t = mk_tri(SIDE_R | SIDE_U,  0, -1,  1, -1);
                3'd6:    t = mk_tri(SIDE_R | SIDE_D,  1,  0,  1,  1);
                default: t = mk_tri(SIDE_R | SIDE_D,  1,  1,  0,  1);
            endcase
        end else begin
            case (slot)
                3'd0:    t = mk_tri(SIDE_L | SIDE_U, -1,  0,  0, -1);
                3'd1:    t = mk_tri(SIDE_L | SIDE_D,  0,  1, -1,  0);
                3'd2:    t = mk_tri(SIDE_R | SIDE_U,  0, -1,  1,  0);
                3'd3:    t = mk_tri(SIDE_R | SIDE_D,  1,  0,  0,  1);
                default: t = '0;
            endcase
        end
        return t;
    endfunction

    // row-major window slot of offset (dr, dc)
    function automatic logic [3:0] win_idx(logic signed [1:0] dr, logic signed [1:0] dc);
        return 4'((int'(dr) + 1) * 3 + (int'(dc) + 1));
    endfunction

    function automatic logic signed [17:0] sgn_mul(logic signed [1:0] s,
                                                  logic signed [16:0] x);
        logic signed [17:0] r;
        case (s)
            2'sb01:  r = 18'(x);
            2'sb11:  r = -18'(x);
            default: r = '0;
        endcase
        return r;
    endfunction

    // normalizer geometry as a function of input width
    function automatic int norm_smw(int w);
        return (w > 31) ? 31 : w;
    endfunction

    function automatic int norm_lat(int w);
        return norm_smw(w) + 7 + DIV_STEPS;
    endfunction

endpackage

// File: design/hvn_norm.sv
// ----------------------------------------------------------------------------
// hvn_norm
// Pipelined vector normalizer to Q1.14: magnitude prescale, squares,
// one integer square root bit per stage, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hvn_norm #(
    parameter int W = 34
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_vec [3],
    output logic signed [15:0]  o_vec [3],
    output logic                o_ok
);

    localparam int MW  = W;
    localparam int SMW = hvn_pkg::norm_smw(W);
    localparam int SH  = MW - SMW;
    localparam int SW  = $clog2(SH + 2);
    localparam int L2W = 2 * SMW + 2;
    localparam int LW  = SMW + 1;
    localparam int SQ  = SMW + 1;
    localparam int DS  = hvn_pkg::DIV_STEPS;
    localparam int RW  = LW + 16;
    localparam int QW  = hvn_pkg::QW;

    logic [MW-1:0]      r1_mag [3];
    logic               r1_sgn [3];
    logic [SMW-1:0]     r2_mag [3];
    logic               r2_sgn [3];
    logic [2*SMW-1:0]   r3_sq  [3];
    logic [SMW-1:0]     r3_mag [3];
    logic               r3_sgn [3];

    logic [L2W-1:0]     r_sn   [SQ+1];
    logic [L2W-1:0]     r_sr   [SQ+1];
    logic [SMW-1:0]     r_smag [SQ+1][3];
    logic               r_ssgn [SQ+1][3];

    logic [LW:0]        r_dd   [DS+1];
    logic               r_dok  [DS+1];
    logic [RW-1:0]      r_dr   [DS+1][3];
    logic [QW-1:0]      r_dq   [DS+1][3];
    logic               r_dsgn [DS+1][3];

    logic [MW-1:0]      w_max;
    logic [SW-1:0]      w_shift;
    logic [LW-1:0]      w_len;

    // stage 1: magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_sgn[i] <= i_vec[i][W-1];
                r1_mag[i] <= i_vec[i][W-1] ? MW'(-i_vec[i]) : MW'(i_vec[i]);
            end
        end
    end

    // stage 2: smallest shift that brings the largest below 2^31
    always_comb begin
        w_max = r1_mag[0];
        if (r1_mag[1] > w_max) w_max = r1_mag[1];
        if (r1_mag[2] > w_max) w_max = r1_mag[2];
        w_shift = SW'(SH);
        for (int k = SH; k >= 0; k--) begin
            if (((w_max >> k) >> 31) == '0) w_shift = SW'(k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r2_mag[i] <= SMW'(r1_mag[i] >> w_shift);
                r2_sgn[i] <= r1_sgn[i];
            end
        end
    end

    // stage 3: squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_sq[i]  <= (2*SMW)'(r2_mag[i]) * (2*SMW)'(r2_mag[i]);
                r3_mag[i] <= r2_mag[i];
                r3_sgn[i] <= r2_sgn[i];
            end
        end
    end

    // sum of squares, root accumulator cleared
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sn[0] <= L2W'(r3_sq[0]) + L2W'(r3_sq[1]) + L2W'(r3_sq[2]);
            r_sr[0] <= '0;
            for (int i = 0; i < 3; i++) begin
                r_smag[0][i] <= r3_mag[i];
                r_ssgn[0][i] <= r3_sgn[i];
            end
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 1; k <= SQ; k++) begin : g_sqrt
        localparam logic [L2W-1:0] BIT = L2W'(1) << (2 * (SQ - k));
        logic [L2W-1:0] w_rb;
        assign w_rb = r_sr[k-1] + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_sn[k-1] >= w_rb) begin
                    r_sn[k] <= r_sn[k-1] - w_rb;
                    r_sr[k] <= (r_sr[k-1] >> 1) + BIT;
                end else begin
                    r_sn[k] <= r_sn[k-1];
                    r_sr[k] <= r_sr[k-1] >> 1;
                end
                for (int i = 0; i < 3; i++) begin
                    r_smag[k][i] <= r_smag[k-1][i];
                    r_ssgn[k][i] <= r_ssgn[k-1][i];
                end
            end
        end
    end

    assign w_len = r_sr[SQ][LW-1:0];

    // divide setup: (mag*32768 + len) / (2*len)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dd[0]  <= {w_len, 1'b0};
            r_dok[0] <= (w_len != '0);
            for (int i = 0; i < 3; i++) begin
                r_dr[0][i]   <= (RW'(r_smag[SQ][i]) << 15) + RW'(w_len);
                r_dq[0][i]   <= '0;
                r_dsgn[0][i] <= r_ssgn[SQ][i];
            end
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 1; j <= DS; j++) begin : g_div
        localparam int B = DS - j;
        logic [RW-1:0] w_dsh;
        assign w_dsh = RW'(r_dd[j-1]) << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dd[j]  <= r_dd[j-1];
                r_dok[j] <= r_dok[j-1];
                for (int i = 0; i < 3; i++) begin
                    r_dsgn[j][i] <= r_dsgn[j-1][i];
                    if (r_dr[j-1][i] >= w_dsh) begin
                        r_dr[j][i]    <= r_dr[j-1][i] - w_dsh;
                        r_dq[j][i]    <= r_dq[j-1][i] | (QW'(1) << B);
                    end else begin
                        r_dr[j][i]    <= r_dr[j-1][i];
                        r_dq[j][i]    <= r_dq[j-1][i];
                    end
                end
            end
        end
    end

    // clamp and restore sign
    always_ff @(posedge i_clk) begin
        logic [QW-1:0] q;
        if (i_en) begin
            o_ok <= r_dok[DS];
            for (int i = 0; i < 3; i++) begin
                q = (r_dq[DS][i] > QW'(hvn_pkg::Q_ONE)) ? QW'(hvn_pkg::Q_ONE) : r_dq[DS][i];
                o_vec[i] <= r_dsgn[DS][i] ? -16'(q) : 16'(q);
            end
        end
    end

endmodule

// File: design/heightmap_vertex_normal_top.sv
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_top
// Per-vertex normal of a diamond-cut height grid from a 3x3 elevation window.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------
//  in       | in        | i_in_valid / o_in_ready   | i_in_data  (t_in)
//  out      | out       | o_out_valid / i_out_ready | o_out_data (t_out)
//  cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One item per cycle while the skid slot is empty. 101 register stages:
//  3 front stages, triangle normalizer (53), 3 adder-tree stages, final
//  normalizer (41), output register.
//  Normalizer depths are set by their square-root and divide chains,
//  one root or quotient bit per stage.
//  Reset clears the pipe and output buffer valid bits and loads the config
//  registers with defaults. A stall freezes the whole pipe only once the
//  output skid slot is full, so one finished item may wait while input is taken.
// ----------------------------------------------------------------------------
module heightmap_vertex_normal_top #(
    parameter int MAX_COLUMNS = hvn_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = hvn_pkg::MAX_ROWS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hvn_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hvn_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);

    localparam int TW = 34;                      // triangle normal width
    localparam int SW = 19;                      // summed normal width
    localparam int L1 = hvn_pkg::norm_lat(TW);
    localparam int L2 = hvn_pkg::norm_lat(SW);
    localparam int NV = 6 + L1 + L2;

    // config registers
    logic [15:0] r_col_spacing;
    logic [15:0] r_row_spacing;
    logic [10:0] r_grid_columns;
    logic [12:0] r_grid_rows;
    logic [31:0] r_dxdz;

    // pipeline control
    logic          r_vld [NV];
    logic          w_en;
    logic          w_push;
    logic          w_pop;

    // front stages
    logic signed [15:0] r1_elev [9];
    logic [3:0]         r1_sides;
    logic               r1_odd;
    logic [16:0]        w_ncols;
    logic [16:0]        w_nrows;
    logic [3:0]         w_sides;

    logic signed [17:0] r2_t0 [8];
    logic signed [2:0]  r2_t1 [8];
    logic signed [17:0] r2_t2 [8];
    logic               r2_pres [8];

    logic signed [TW-1:0] r3_n [8][3];

    // normalizer outputs and sum tree
    logic signed [15:0] w_tn  [8][3];
    logic               w_tok [8];
    logic signed [16:0] w_ctr [8][3];
    logic signed [16:0] r_t1  [4][3];
    logic signed [17:0] r_t2  [2][3];
    logic signed [SW-1:0] r_t3 [3];
    logic signed [15:0] w_fn  [3];
    logic               w_fok;
    hvn_pkg::t_out      w_res;

    // output buffer: result register plus one skid slot
    logic          r_out_v;
    hvn_pkg::t_out r_out;
    logic          r_skid_v;
    hvn_pkg::t_out r_skid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_spacing  <= 16'd256;
            r_row_spacing  <= 16'd256;
            r_grid_columns <= 11'd2;
            r_grid_rows    <= 13'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hvn_pkg::CFG_COLUMN_SPACING: r_col_spacing  <= i_cfg_data;
                hvn_pkg::CFG_ROW_SPACING:    r_row_spacing  <= i_cfg_data;
                hvn_pkg::CFG_GRID_COLUMNS:   r_grid_columns <= i_cfg_data[10:0];
                hvn_pkg::CFG_GRID_ROWS:      r_grid_rows    <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // product used by the y component of every triangle
    always_ff @(posedge i_clk) begin
        r_dxdz <= 32'(r_col_spacing) * 32'(r_row_spacing);
    end

    // whole pipe moves unless the skid slot is occupied
    assign w_en       = ~r_skid_v;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NV; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < NV; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // stage 1: window capture and edge tests
    always_comb begin
        w_ncols = (17'(r_grid_columns) > 17'(MAX_COLUMNS)) ? 17'(MAX_COLUMNS)
                                                           : 17'(r_grid_columns);
        w_nrows = (17'(r_grid_rows) > 17'(MAX_ROWS)) ? 17'(MAX_ROWS)
                                                     : 17'(r_grid_rows);
        w_sides = '0;
        if (i_in_data.col_index != '0)                   w_sides |= hvn_pkg::SIDE_L;
        if (17'(i_in_data.col_index) + 17'd1 < w_ncols)  w_sides |= hvn_pkg::SIDE_R;
        if (i_in_data.row_index != '0)                   w_sides |= hvn_pkg::SIDE_U;
        if (17'(i_in_data.row_index) + 17'd1 < w_nrows)  w_sides |= hvn_pkg::SIDE_D;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_elev[0] <= i_in_data.elev_up_left;
            r1_elev[1] <= i_in_data.elev_up;
            r1_elev[2] <= i_in_data.elev_up_right;
            r1_elev[3] <= i_in_data.elev_left;
            r1_elev[4] <= i_in_data.elev_center;
            r1_elev[5] <= i_in_data.elev_right;
            r1_elev[6] <= i_in_data.elev_down_left;
            r1_elev[7] <= i_in_data.elev_down;
            r1_elev[8] <= i_in_data.elev_down_right;
            r1_sides   <= w_sides;
            r1_odd     <= i_in_data.col_index[0] ^ i_in_data.row_index[0];
        end
    end

    // stages 2 and 3, one lane per triangle slot
    for (genvar g = 0; g < 8; g++) begin : g_tri
        localparam hvn_pkg::t_tri TE = hvn_pkg::tri_info(1'b0, 3'(g));
        localparam hvn_pkg::t_tri TO = hvn_pkg::tri_info(1'b1, 3'(g));
        localparam logic [3:0] IAE = hvn_pkg::win_idx(TE.ar, TE.ac);
        localparam logic [3:0] IBE = hvn_pkg::win_idx(TE.br, TE.bc);
        localparam logic [3:0] IAO = hvn_pkg::win_idx(TO.ar, TO.ac);
        localparam logic [3:0] IBO = hvn_pkg::win_idx(TO.br, TO.bc);
        localparam logic signed [2:0] T1E =
            3'(int'(TE.ac) * int'(TE.br) - int'(TE.ar) * int'(TE.bc));
        localparam logic signed [2:0] T1O =
            3'(int'(TO.ac) * int'(TO.br) - int'(TO.ar) * int'(TO.bc));

        logic signed [16:0] w_hae, w_hbe, w_hao, w_hbo;
        logic               w_pe, w_po;

        assign w_hae = 17'(r1_elev[IAE]) - 17'(r1_elev[hvn_pkg::WIN_CENTER]);
        assign w_hbe = 17'(r1_elev[IBE]) - 17'(r1_elev[hvn_pkg::WIN_CENTER]);
        assign w_hao = 17'(r1_elev[IAO]) - 17'(r1_elev[hvn_pkg::WIN_CENTER]);
        assign w_hbo = 17'(r1_elev[IBO]) - 17'(r1_elev[hvn_pkg::WIN_CENTER]);
        assign w_pe  = TE.present && ((TE.sides & r1_sides) == TE.sides);
        assign w_po  = TO.present && ((TO.sides & r1_sides) == TO.sides);

        // cross product with the spacings factored out
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (r1_odd) begin
                    r2_t0[g]   <= hvn_pkg::sgn_mul(TO.ar, w_hbo) - hvn_pkg::sgn_mul(TO.br, w_hao);
                    r2_t1[g]   <= T1O;
                    r2_t2[g]   <= hvn_pkg::sgn_mul(TO.ac, w_hbo) - hvn_pkg::sgn_mul(TO.bc, w_hao);
                    r2_pres[g] <= w_po;
                end else begin
                    r2_t0[g]   <= hvn_pkg::sgn_mul(TE.ar, w_hbe) - hvn_pkg::sgn_mul(TE.br, w_hae);
                    r2_t1[g]   <= T1E;
                    r2_t2[g]   <= hvn_pkg::sgn_mul(TE.ac, w_hbe) - hvn_pkg::sgn_mul(TE.bc, w_hae);
                    r2_pres[g] <= w_pe;
                end
            end
        end

        // scale by spacings; missing triangles become a zero vector
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (r2_pres[g]) begin
                    r3_n[g][0] <= TW'($signed({1'b0, r_row_spacing}) * r2_t0[g]);
                    r3_n[g][1] <= TW'($signed({1'b0, r_dxdz}) * r2_t1[g]);
                    r3_n[g][2] <= TW'($signed({1'b0, r_col_spacing}) * r2_t2[g]);
                end else begin
                    r3_n[g][0] <= '0;
                    r3_n[g][1] <= '0;
                    r3_n[g][2] <= '0;
                end
            end
        end

        hvn_norm #(.W(TW)) u_tri_norm (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_vec (r3_n[g]),
            .o_vec (w_tn[g]),
            .o_ok  (w_tok[g])
        );

        for (genvar c = 0; c < 3; c++) begin : g_ctr
            assign w_ctr[g][c] = w_tok[g] ? 17'(w_tn[g][c]) : '0;
        end
    end

    // registered adder tree over the eight unit normals
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                for (int p = 0; p < 4; p++) r_t1[p][c] <= w_ctr[2*p][c] + w_ctr[2*p+1][c];
                for (int p = 0; p < 2; p++) r_t2[p][c] <= 18'(r_t1[2*p][c]) + 18'(r_t1[2*p+1][c]);
                r_t3[c] <= SW'(r_t2[0][c]) + SW'(r_t2[1][c]);
            end
        end
    end

    hvn_norm #(.W(SW)) u_sum_norm (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_vec (r_t3),
        .o_vec (w_fn),
        .o_ok  (w_fok)
    );

    // zero sum means no usable triangle: report straight up
    always_comb begin
        if (w_fok) begin
            w_res.normal_x = w_fn[0];
            w_res.normal_y = w_fn[1];
            w_res.normal_z = w_fn[2];
        end else begin
            w_res.normal_x = '0;
            w_res.normal_y = 16'(hvn_pkg::Q_ONE);
            w_res.normal_z = '0;
        end
    end

    assign w_push = w_en & r_vld[NV-1];
    assign w_pop  = r_out_v & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_pop) begin
                if (r_skid_v) begin
                    r_out    <= r_skid;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v  <= w_push;
                    r_out    <= w_res;
                end
            end else if (w_push) begin
                if (!r_out_v) begin
                    r_out_v <= 1'b1;
                    r_out   <= w_res;
                end else begin
                    r_skid_v <= 1'b1;
                    r_skid   <= w_res;
                end
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid slot full while output register empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_out_ready))
        else $error("skid slot filled without an output stall");

    a_accept_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted item not tracked in valid line");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.normal_x <= 16384 && o_out_data.normal_x >= -16384
                      && o_out_data.normal_y <= 16384 && o_out_data.normal_y >= -16384
                      && o_out_data.normal_z <= 16384 && o_out_data.normal_z >= -16384))
        else $error("normal component outside Q1.14 unit range");
`endif

endmodule

// File: test/hvn_normal_checker.sv
// ----------------------------------------------------------------------------
// hvn_normal_checker
// Watches the config, input and output channels of the vertex normal block,
// computes the expected Q1.14 normal for every accepted vertex and compares.
// ----------------------------------------------------------------------------
module hvn_normal_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  hvn_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  hvn_pkg::t_out i_out_data,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output int            o_errors,
    output int            o_pending,
    output int            o_normals_seen
);

    typedef longint signed t_vec3 [3];

    logic [15:0] col_step;
    logic [15:0] row_step;
    logic [10:0] n_cols;
    logic [12:0] n_rows;

    hvn_pkg::t_out normal_queue [$];

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // scale to Q1.14, zero vector gives ok = 0
    function automatic bit unit_vec(input t_vec3 v, output t_vec3 o);
        longint unsigned mag [3];
        longint unsigned mx, len2, len, q;
        int sh;
        mx = 0;
        len2 = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > mx) mx = mag[i];
        end
        while ((mx >> sh) >= (64'd1 << 31)) sh++;
        for (int i = 0; i < 3; i++) begin
            mag[i] = mag[i] >> sh;
            len2 += mag[i] * mag[i];
        end
        len = root_floor(len2);
        for (int i = 0; i < 3; i++) o[i] = 0;
        if (len == 0) return 1'b0;
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 32768 + len) / (2 * len);
            if (q > 16384) q = 16384;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic hvn_pkg::t_out vertex_normal(hvn_pkg::t_in d);
        longint signed win [9];
        longint unsigned nc, nr;
        longint signed dx, dz;
        t_vec3 sum, res, a, b, n, u;
        logic [3:0] sides;
        logic odd;
        hvn_pkg::t_out r;
        win[0] = d.elev_up_left;   win[1] = d.elev_up;   win[2] = d.elev_up_right;
        win[3] = d.elev_left;      win[4] = d.elev_center; win[5] = d.elev_right;
        win[6] = d.elev_down_left; win[7] = d.elev_down; win[8] = d.elev_down_right;
        nc = (n_cols > 1024) ? 1024 : n_cols;
        nr = (n_rows > 4096) ? 4096 : n_rows;
        dx = col_step;
        dz = row_step;
        sides = '0;
        if (d.col_index > 0) sides |= hvn_pkg::SIDE_L;
        if (longint'(d.col_index) + 1 < nc) sides |= hvn_pkg::SIDE_R;
        if (d.row_index > 0) sides |= hvn_pkg::SIDE_U;
        if (longint'(d.row_index) + 1 < nr) sides |= hvn_pkg::SIDE_D;
        odd = d.col_index[0] ^ d.row_index[0];
        for (int j = 0; j < 3; j++) sum[j] = 0;
        for (int i = 0; i < 8; i++) begin
            // own triangle table, same geometry as the diamond cut
            int ac, ar, bc, br;
            logic [3:0] need;
            if (odd && i > 3) continue;
            if (!odd) begin
                case (i)
                    0: begin need = hvn_pkg::SIDE_L | hvn_pkg::SIDE_U;
                        ac=-1; ar=-1; bc= 0; br=-1; end
                    1: begin need = hvn_pkg::SIDE_L | hvn_pkg::SIDE_U;
                        ac=-1; ar= 0; bc=-1; br=-1; end
                    2: begin need = hvn_pkg::SIDE_L | hvn_pkg::SIDE_D;
                        ac=-1; ar= 1; bc=-1; br= 0; end
                    3: begin need = hvn_pkg::SIDE_L | hvn_pkg::SIDE_D;
                        ac= 0; ar= 1; bc=-1; br= 1; end
                    4: begin need = hvn_pkg::SIDE_R | hvn_pkg::SIDE_U;
                        ac= 1; ar=-1; bc= 1; br= 0; end
                    5: begin need = hvn_pkg::SIDE_R | hvn_pkg::SIDE_U;
                        ac= 0; ar=-1; bc= 1; br=-1; end
                    6: begin need = hvn_pkg::SIDE_R | hvn_pkg::SIDE_D;
                        ac= 1; ar= 0; bc= 1; br= 1; end
                    default: begin need = hvn_pkg::SIDE_R | hvn_pkg::SIDE_D;
                        ac=1; ar=1; bc=0; br=1; end
                endcase
            end else begin
                case (i)
                    0: begin need = hvn_pkg::SIDE_L | hvn_pkg::SIDE_U;
                        ac=-1; ar= 0; bc= 0; br=-1; end
                    1: begin need = hvn_pkg::SIDE_L | hvn_pkg::SIDE_D;
                        ac= 0; ar= 1; bc=-1; br= 0; end
                    2: begin need = hvn_pkg::SIDE_R | hvn_pkg::SIDE_U;
                        ac= 0; ar=-1; bc= 1; br= 0; end
                    default: begin need = hvn_pkg::SIDE_R | hvn_pkg::SIDE_D;
                        ac=1; ar=0; bc=0; br=1; end
                endcase
            end
            if ((need & sides) != need) continue;
            a[0] = ac * dx; a[1] = win[(ar+1)*3 + ac+1] - win[4]; a[2] = -(ar * dz);
            b[0] = bc * dx; b[1] = win[(br+1)*3 + bc+1] - win[4]; b[2] = -(br * dz);
            n[0] = a[1]*b[2] - a[2]*b[1];
            n[1] = a[2]*b[0] - a[0]*b[2];
            n[2] = a[0]*b[1] - a[1]*b[0];
            if (unit_vec(n, u)) for (int j = 0; j < 3; j++) sum[j] += u[j];
        end
        if (!unit_vec(sum, res)) begin
            res[0] = 0; res[1] = 16384; res[2] = 0;
        end
        r.normal_x = 16'(res[0]);
        r.normal_y = 16'(res[1]);
        r.normal_z = 16'(res[2]);
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        hvn_pkg::t_out want;
        int bad;
        bad = 0;
        if (!i_rst_n) begin
            col_step <= 16'd256;
            row_step <= 16'd256;
            n_cols   <= 11'd2;
            n_rows   <= 13'd2;
            o_errors <= 0;
            o_normals_seen <= 0;
            normal_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    hvn_pkg::CFG_COLUMN_SPACING: col_step <= i_cfg_data;
                    hvn_pkg::CFG_ROW_SPACING:    row_step <= i_cfg_data;
                    hvn_pkg::CFG_GRID_COLUMNS:   n_cols   <= i_cfg_data[10:0];
                    hvn_pkg::CFG_GRID_ROWS:      n_rows   <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) normal_queue.push_back(vertex_normal(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_normals_seen <= o_normals_seen + 1;
                if (normal_queue.size() == 0) begin
                    $error("unexpected normal %h", i_out_data);
                    bad = 1;
                end else begin
                    want = normal_queue.pop_front();
                    if (i_out_data.normal_x !== want.normal_x) begin
                        $error("normal_x exp %0d got %0d", want.normal_x, i_out_data.normal_x);
                        bad++;
                    end
                    if (i_out_data.normal_y !== want.normal_y) begin
                        $error("normal_y exp %0d got %0d", want.normal_y, i_out_data.normal_y);
                        bad++;
                    end
                    if (i_out_data.normal_z !== want.normal_z) begin
                        $error("normal_z exp %0d got %0d", want.normal_z, i_out_data.normal_z);
                        bad++;
                    end
                end
            end
            if (bad != 0) o_errors <= o_errors + bad;
        end
    end

    // items predicted but not yet seen at the output
    assign o_pending = normal_queue.size();

endmodule

// File: test/tb_heightmap_vertex_normal_top.sv
// ----------------------------------------------------------------------------
// tb_heightmap_vertex_normal_top
// Drives vertex windows and config writes into the normal block with random
// gaps and stalls; a side checker predicts each normal and counts mismatches.
// ----------------------------------------------------------------------------
module tb_heightmap_vertex_normal_top;

    localparam int PIPE_DEPTH  = 100;  // accepting edge to o_out_valid
    localparam int STALL_LIMIT = 20000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    hvn_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_ready;
    hvn_pkg::t_out o_out_data;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [7:0]    i_cfg_index;
    logic [15:0]   i_cfg_data;

    int  errors, pending, normals_seen;
    int  idle_cycles;
    bit  hold_sink;       // long receiver hold-off while the sender keeps pushing
    bit  in_live;         // valid still up from the last accepted item
    int  vertices_sent;

    heightmap_vertex_normal_top u_dut (.*);

    hvn_normal_checker u_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_data(o_out_data),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_normals_seen(normals_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---- item and config drivers ----
    task automatic drop_valid();
        if (in_live) begin
            i_in_valid <= 1'b0;
            in_live = 1'b0;
        end
    endtask

    task automatic send_vertex(hvn_pkg::t_in d);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;  // stretches without gaps
        if (gap > 0) begin
            drop_valid();
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do @(posedge i_clk); while (!o_in_ready);
        in_live = 1'b1;
        vertices_sent++;
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        drop_valid();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain everything outstanding before touching registers
    task automatic drain();
        drop_valid();
        while (pending != 0 || i_in_valid) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
    endtask

    task automatic set_grid(logic [15:0] cs, logic [15:0] rs, logic [15:0] nc,
                            logic [15:0] nr);
        drain();
        write_reg(hvn_pkg::CFG_COLUMN_SPACING, cs);
        write_reg(hvn_pkg::CFG_ROW_SPACING, rs);
        write_reg(hvn_pkg::CFG_GRID_COLUMNS, nc);
        write_reg(hvn_pkg::CFG_GRID_ROWS, nr);
    endtask

    function automatic hvn_pkg::t_in rand_vertex(int ncols, int nrows, int spread);
        hvn_pkg::t_in d;
        int base;
        d = '0;
        // mostly in-grid indexes, sometimes anywhere
        if ($urandom_range(0, 7) == 0) begin
            d.col_index = 10'($urandom);
            d.row_index = 12'($urandom);
        end else begin
            d.col_index = 10'($urandom_range(0, (ncols > 1024 ? 1024 : ncols) - 1));
            d.row_index = 12'($urandom_range(0, (nrows > 4096 ? 4096 : nrows) - 1));
        end
        base = int'($urandom_range(0, 65535)) - 32768;
        if (spread == 0) begin
            {d.elev_center, d.elev_up, d.elev_down, d.elev_left, d.elev_right,
             d.elev_up_left, d.elev_up_right, d.elev_down_left, d.elev_down_right} =
                144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        end else begin
            d.elev_center     = 16'(base);
            d.elev_up         = 16'(base + int'($urandom_range(0, 2*spread)) - spread);
            d.elev_down       = 16'(base + int'($urandom_range(0, 2*spread)) - spread);
            d.elev_left       = 16'(base + int'($urandom_range(0, 2*spread)) - spread);
            d.elev_right      = 16'(base + int'($urandom_range(0, 2*spread)) - spread);
            d.elev_up_left    = 16'(base + int'($urandom_range(0, 2*spread)) - spread);
            d.elev_up_right   = 16'(base + int'($urandom_range(0, 2*spread)) - spread);
            d.elev_down_left  = 16'(base + int'($urandom_range(0, 2*spread)) - spread);
            d.elev_down_right = 16'(base + int'($urandom_range(0, 2*spread)) - spread);
        end
        return d;
    endfunction

    // ---- receiver: random stalls, plus one long hold-off ----
    initial begin
        int w;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_sink) begin
                i_out_ready <= 1'b0;
                @(posedge i_clk);
            end else begin
                w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                if (w > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (w) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                do @(posedge i_clk); while (!(o_out_valid && i_out_ready) && !hold_sink);
            end
        end
    end

    // ---- watchdog: cycles with nothing accepted ----
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || hold_sink)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        hvn_pkg::t_in d;
        int nc, nr;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        hold_sink = 1'b0;
        vertices_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset grid 2x2 with default spacing: corner vertices
        for (int i = 0; i < 4; i++) begin
            d = '0;
            d.col_index = 10'(i & 1);
            d.row_index = 12'(i >> 1);
            d.elev_center = 16'(256 * i);
            d.elev_right = 16'sh7fff;
            d.elev_down = -16'sh8000;
            send_vertex(d);
        end

        // directed: extremes, flat, both parities, grid corner indexes
        set_grid(16'd256, 16'd256, 16'd1024, 16'd4096);
        d = '0; d.col_index = 10'd5; d.row_index = 12'd7; send_vertex(d);  // flat
        d.col_index = 10'd6; send_vertex(d);
        d = '1; d.col_index = 10'd1023; d.row_index = 12'd4095; send_vertex(d);
        d = '0; d.col_index = 10'd0; d.row_index = 12'd0;
        d.elev_center = -16'sh8000;
        {d.elev_up, d.elev_down, d.elev_left, d.elev_right, d.elev_up_left,
         d.elev_up_right, d.elev_down_left, d.elev_down_right} = {8{16'sh7fff}};
        send_vertex(d);
        d.col_index = 10'd512; d.row_index = 12'd2047; send_vertex(d);
        d.col_index = 10'd511; send_vertex(d);
        d.elev_center = 16'sh7fff;
        {d.elev_up, d.elev_down, d.elev_left, d.elev_right, d.elev_up_left,
         d.elev_up_right, d.elev_down_left, d.elev_down_right} = {8{-16'sh8000}};
        send_vertex(d);
        // extreme spacing, and an oversized grid clamped to the maximum
        set_grid(16'hffff, 16'd1, 16'd2047, 16'd8191);
        d.col_index = 10'd1023; d.row_index = 12'd4095; send_vertex(d);
        d.col_index = 10'd100; d.row_index = 12'd100; send_vertex(d);
        // degenerate triangles: zero spacing, flat ground
        set_grid(16'd0, 16'd0, 16'd8, 16'd8);
        d = '0; d.col_index = 10'd3; d.row_index = 12'd3; send_vertex(d);
        d.elev_up = 16'sd500; send_vertex(d);
        // index beyond grid acts as right and bottom edge; unknown register ignored
        drain();
        write_reg(8'd4, 16'h1234);
        write_reg(8'hff, 16'hffff);
        write_reg(hvn_pkg::CFG_COLUMN_SPACING, 16'd1);
        write_reg(hvn_pkg::CFG_ROW_SPACING, 16'hffff);
        d.col_index = 10'd900; d.row_index = 12'd900; send_vertex(d);
        d.col_index = 10'd7; d.row_index = 12'd0; send_vertex(d);

        // random phases over several grid settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin nc = 2;    nr = 2; end
                1: begin nc = 16;   nr = 16; end
                2: begin nc = 1024; nr = 4096; end
                3: begin nc = 2047; nr = 3; end
                4: begin nc = $urandom_range(2, 64); nr = $urandom_range(2, 64); end
                default: begin nc = 5; nr = 8191; end
            endcase
            set_grid(ph == 2 ? 16'hffff : 16'($urandom_range(1, 2048)),
                     ph == 0 ? 16'd1 : 16'($urandom_range(1, 2048)),
                     16'(nc), 16'(nr));
            for (int k = 0; k < 240; k++) begin
                // long receiver hold-off once, while vertices keep coming
                if (ph == 1 && k == 20) begin
                    fork
                        begin
                            hold_sink = 1'b1;
                            repeat (400) @(posedge i_clk);
                            hold_sink = 1'b0;
                        end
                    join_none
                end
                send_vertex(rand_vertex(nc, nr,
                    ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(0, 14))));
            end
        end

        drain();
        $display("Covered %0d vertices, %0d normals checked: directed edge cases,",
                 vertices_sent, normals_seen);
        $display("six random grid phases and one long output hold-off.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
